// File: hdl/dltq_pkg.sv
package dltq_pkg;

  localparam int QUEUE_DEPTH_DEFAULT = 16;
  localparam int DELAY_W = 24;
  localparam int ID_W = 16;

  localparam logic [1:0] OP_SET    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY     = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic [DELAY_W-1:0] delay_ms;
    logic [ID_W-1:0]    timer_id;
  } cmd_t;

  typedef struct packed {
    logic [1:0]      status;
    logic            expired_valid;
    logic [ID_W-1:0] expired_id;
    logic            last_result;
  } result_t;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delta;
  } entry_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic [DELAY_W-1:0] a;
    logic [DELAY_W-1:0] b;
  } alu_req_t;

  // For a subtraction, carry is the borrow out.
  typedef struct packed {
    logic [DELAY_W-1:0] res;
    logic               carry;
  } alu_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_WALK_RD,
    S_WALK_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_CAN_RD,
    S_CAN_CMP,
    S_REM_RD,
    S_REM_WR,
    S_TK_RD,
    S_TK_DEC,
    S_TK_NEXT,
    S_TK_CHK
  } state_t;

endpackage

// File: hdl/delta_list_timer_queue_unit.sv
// Channel   Ports                         Handshake
// command   start, busy, command          taken when start is high and busy is low
// result    result_valid, result          one cycle per item, always taken
//
// A set walks past the entries that expire no later than the new one, moves the later
// entries down and writes the new one; a cancel walks to the matching entry and moves
// the later entries up. A tick decrements the head and removes each expired timer.
// A set into a full queue, a cancel or tick on an empty queue and the unused code are
// answered without leaving idle. The entry memory has a single read port. Reset clears
// the sequencer and the entry count; the entry memory is not cleared. Results cannot
// be stalled.
module delta_list_timer_queue_unit #(
  parameter int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dltq_pkg::cmd_t    command,
  output logic              busy,
  output logic              result_valid,
  output dltq_pkg::result_t result
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  dltq_pkg::entry_t   mem_wdata;
  logic [AW-1:0]      mem_raddr;
  dltq_pkg::entry_t   mem_rdata;
  dltq_pkg::alu_req_t alu_req;
  dltq_pkg::alu_rsp_t alu_rsp;

  dltq_ctrl #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW(AW),
    .CW(CW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(command),
    .busy(busy),
    .result_valid(result_valid),
    .result(result),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata),
    .alu_req(alu_req),
    .alu_rsp(alu_rsp)
  );

  dltq_mem #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  dltq_alu u_alu (
    .req(alu_req),
    .rsp(alu_rsp)
  );

endmodule

// File: hdl/dltq_alu.sv
module dltq_alu (
  input  dltq_pkg::alu_req_t req,
  output dltq_pkg::alu_rsp_t rsp
);

  logic [dltq_pkg::DELAY_W:0] b_ext;
  logic                       cin;
  logic [dltq_pkg::DELAY_W:0] sum;

  // One adder serves both operations: a - b is a + ~b + 1.
  always_comb begin
    if (req.op == dltq_pkg::ALU_SUB) begin
      b_ext = ~{1'b0, req.b};
      cin   = 1'b1;
    end else begin
      b_ext = {1'b0, req.b};
      cin   = 1'b0;
    end
    sum = {1'b0, req.a} + b_ext + {{dltq_pkg::DELAY_W{1'b0}}, cin};
    rsp.res   = sum[dltq_pkg::DELAY_W-1:0];
    rsp.carry = sum[dltq_pkg::DELAY_W];
  end

endmodule

// File: hdl/dltq_mem.sv
module dltq_mem #(
  parameter int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int AW = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  dltq_pkg::entry_t wdata,
  input  logic [AW-1:0]    raddr,
  output dltq_pkg::entry_t rdata
);

  dltq_pkg::entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/dltq_ctrl.sv
module dltq_ctrl #(
  parameter int QUEUE_DEPTH = dltq_pkg::QUEUE_DEPTH_DEFAULT,
  parameter int AW = $clog2(QUEUE_DEPTH),
  parameter int CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  dltq_pkg::cmd_t     command,
  output logic               busy,
  output logic               result_valid,
  output dltq_pkg::result_t  result,
  output logic               mem_we,
  output logic [AW-1:0]      mem_waddr,
  output dltq_pkg::entry_t   mem_wdata,
  output logic [AW-1:0]      mem_raddr,
  input  dltq_pkg::entry_t   mem_rdata,
  output dltq_pkg::alu_req_t alu_req,
  input  dltq_pkg::alu_rsp_t alu_rsp
);

  dltq_pkg::state_t state, state_next;

  dltq_pkg::cmd_t                cmd_q;
  logic [CW-1:0]                 count;
  logic [CW-1:0]                 pos;
  logic [CW-1:0]                 idx;
  logic [dltq_pkg::DELAY_W-1:0]  remain;
  logic [dltq_pkg::DELAY_W-1:0]  cdelta;
  logic                          adj;
  logic [dltq_pkg::ID_W-1:0]     pend_id;

  logic                          emit;
  dltq_pkg::result_t             emit_res;

  logic [CW-1:0] pos_inc;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic          is_full;
  logic          is_empty;
  logic          pos_end;
  logic          rem_end;
  logic          id_match;
  logic          expire;

  assign pos_inc  = pos + CW'(1);
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign is_full  = (count == CW'(QUEUE_DEPTH));
  assign is_empty = (count == '0);
  assign pos_end  = (pos == count);
  assign rem_end  = (idx_inc == count);
  assign id_match = (mem_rdata.id == cmd_q.timer_id);
  // On the tick decrement, the head expires when it was zero or becomes zero.
  assign expire   = alu_rsp.carry || (alu_rsp.res == '0);

  assign busy = (state != dltq_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      dltq_pkg::S_IDLE: begin
        if (start) begin
          case (command.operation)
            dltq_pkg::OP_SET:    state_next = is_full  ? dltq_pkg::S_IDLE : dltq_pkg::S_WALK_RD;
            dltq_pkg::OP_CANCEL: state_next = is_empty ? dltq_pkg::S_IDLE : dltq_pkg::S_CAN_RD;
            dltq_pkg::OP_TICK:   state_next = is_empty ? dltq_pkg::S_IDLE : dltq_pkg::S_TK_RD;
            default:             state_next = dltq_pkg::S_IDLE;
          endcase
        end
      end
      dltq_pkg::S_WALK_RD:  state_next = pos_end ? dltq_pkg::S_SHIFT_RD : dltq_pkg::S_WALK_CMP;
      dltq_pkg::S_WALK_CMP: state_next = alu_rsp.carry ? dltq_pkg::S_SHIFT_RD
                                                       : dltq_pkg::S_WALK_RD;
      dltq_pkg::S_SHIFT_RD: state_next = (idx == pos) ? dltq_pkg::S_INS_WR
                                                      : dltq_pkg::S_SHIFT_WR;
      dltq_pkg::S_SHIFT_WR: state_next = dltq_pkg::S_SHIFT_RD;
      dltq_pkg::S_INS_WR:   state_next = dltq_pkg::S_IDLE;
      dltq_pkg::S_CAN_RD:   state_next = pos_end ? dltq_pkg::S_IDLE : dltq_pkg::S_CAN_CMP;
      dltq_pkg::S_CAN_CMP:  state_next = id_match ? dltq_pkg::S_REM_RD : dltq_pkg::S_CAN_RD;
      dltq_pkg::S_REM_RD: begin
        if (!rem_end) begin
          state_next = dltq_pkg::S_REM_WR;
        end else if (cmd_q.operation == dltq_pkg::OP_TICK) begin
          state_next = dltq_pkg::S_TK_NEXT;
        end else begin
          state_next = dltq_pkg::S_IDLE;
        end
      end
      dltq_pkg::S_REM_WR:   state_next = dltq_pkg::S_REM_RD;
      dltq_pkg::S_TK_RD:    state_next = dltq_pkg::S_TK_DEC;
      dltq_pkg::S_TK_DEC:   state_next = expire ? dltq_pkg::S_REM_RD : dltq_pkg::S_IDLE;
      dltq_pkg::S_TK_NEXT:  state_next = is_empty ? dltq_pkg::S_IDLE : dltq_pkg::S_TK_CHK;
      dltq_pkg::S_TK_CHK:   state_next = (mem_rdata.delta == '0) ? dltq_pkg::S_REM_RD
                                                                 : dltq_pkg::S_IDLE;
      default:              state_next = dltq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = pos[AW-1:0];
    alu_req.op = dltq_pkg::ALU_SUB;
    alu_req.a  = mem_rdata.delta;
    alu_req.b  = remain;
    emit     = 1'b0;
    emit_res = '{status: dltq_pkg::ST_OK, expired_valid: 1'b0,
                 expired_id: '0, last_result: 1'b1};
    case (state)
      dltq_pkg::S_IDLE: begin
        if (start) begin
          case (command.operation)
            dltq_pkg::OP_SET: begin
              emit = is_full;
              emit_res.status = dltq_pkg::ST_FULL;
            end
            dltq_pkg::OP_CANCEL: begin
              emit = is_empty;
              emit_res.status = dltq_pkg::ST_EMPTY;
            end
            dltq_pkg::OP_TICK: emit = is_empty;
            default:           emit = 1'b1;
          endcase
        end
      end
      dltq_pkg::S_WALK_CMP: begin
        // The walk continues while the entry's delta fits in what is left.
        alu_req.a = remain;
        alu_req.b = mem_rdata.delta;
      end
      dltq_pkg::S_SHIFT_RD: begin
        mem_raddr = idx_dec[AW-1:0];
      end
      dltq_pkg::S_SHIFT_WR: begin
        mem_we = 1'b1;
        if (idx == pos_inc) begin
          // The new successor gives up the part of its delta the new entry now holds.
          mem_wdata.delta = alu_rsp.res;
        end
      end
      dltq_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos[AW-1:0];
        mem_wdata = '{id: cmd_q.timer_id, delta: remain};
        emit      = 1'b1;
      end
      dltq_pkg::S_CAN_RD: begin
        emit = pos_end;
        emit_res.status = dltq_pkg::ST_NOT_FOUND;
      end
      dltq_pkg::S_REM_RD: begin
        if (!rem_end) begin
          mem_raddr = idx_inc[AW-1:0];
        end
        emit = rem_end && (cmd_q.operation != dltq_pkg::OP_TICK);
      end
      dltq_pkg::S_REM_WR: begin
        mem_we     = 1'b1;
        alu_req.op = dltq_pkg::ALU_ADD;
        alu_req.b  = cdelta;
        if (adj) begin
          mem_wdata.delta = alu_rsp.res;
        end
      end
      dltq_pkg::S_TK_RD: begin
        mem_raddr = '0;
      end
      dltq_pkg::S_TK_DEC: begin
        alu_req.b = dltq_pkg::DELAY_W'(1);
        if (!expire) begin
          mem_we          = 1'b1;
          mem_waddr       = '0;
          mem_wdata.delta = alu_rsp.res;
          emit            = 1'b1;
        end
      end
      dltq_pkg::S_TK_NEXT: begin
        mem_raddr = '0;
        emit = is_empty;
        emit_res.expired_valid = 1'b1;
        emit_res.expired_id    = pend_id;
      end
      dltq_pkg::S_TK_CHK: begin
        emit = 1'b1;
        emit_res.expired_valid = 1'b1;
        emit_res.expired_id    = pend_id;
        emit_res.last_result   = (mem_rdata.delta != '0);
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= dltq_pkg::S_IDLE;
      count        <= '0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= emit;
      if (state == dltq_pkg::S_INS_WR) begin
        count <= count + CW'(1);
      end else if (state == dltq_pkg::S_REM_RD && rem_end) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= emit_res;
    end
    case (state)
      dltq_pkg::S_IDLE: begin
        cmd_q  <= command;
        pos    <= '0;
        idx    <= count;
        remain <= command.delay_ms;
      end
      dltq_pkg::S_WALK_CMP: begin
        if (!alu_rsp.carry) begin
          remain <= alu_rsp.res;
          pos    <= pos_inc;
        end
      end
      dltq_pkg::S_SHIFT_WR: begin
        idx <= idx_dec;
      end
      dltq_pkg::S_CAN_CMP: begin
        if (id_match) begin
          cdelta <= mem_rdata.delta;
          idx    <= pos;
          adj    <= 1'b1;
        end else begin
          pos <= pos_inc;
        end
      end
      dltq_pkg::S_REM_WR: begin
        idx <= idx_inc;
        adj <= 1'b0;
      end
      dltq_pkg::S_TK_DEC: begin
        pend_id <= mem_rdata.id;
        idx     <= '0;
        adj     <= 1'b0;
      end
      dltq_pkg::S_TK_CHK: begin
        pend_id <= mem_rdata.id;
        idx     <= '0;
        adj     <= 1'b0;
      end
      default: begin
        adj <= adj;
      end
    endcase
  end

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import dltq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEFAULT;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 180;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 100;
  localparam logic [DELAY_W-1:0] LONG_DELAY = 24'd16;

  typedef struct {
    cmd_t cmd;
    bit   drain_first;
  } queued_cmd_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  cmd_t    command = '0;
  logic    busy;
  logic    result_valid;
  result_t result;

  delta_list_timer_queue_unit #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk(clk),
    .rst(rst),
    .start(start),
    .command(command),
    .busy(busy),
    .result_valid(result_valid),
    .result(result)
  );

  queued_cmd_t cmd_backlog[$];
  result_t     expected_results[$];
  int          total_items = 0;
  int          accepted_items = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          gap_left = 0;
  int          calm_left = 0;

  // Shadow copy of the timer list, kept in expiry order with relative deltas.
  logic [ID_W-1:0]    timer_ids[DEPTH];
  logic [DELAY_W-1:0] timer_deltas[DEPTH];
  int                 timer_count = 0;

  // Ids handed out by the stimulus, used to aim cancels at issued timers.
  logic [ID_W-1:0] issued_ids[$];
  logic [ID_W-1:0] long_ids[$];

  initial forever #5 clk = ~clk;

  function automatic void timer_remove(int pos);
    for (int i = pos; i + 1 < timer_count; i++) begin
      timer_ids[i] = timer_ids[i + 1];
      timer_deltas[i] = timer_deltas[i + 1];
    end
    timer_count--;
  endfunction

  function automatic void timer_queue_predict(cmd_t c);
    result_t            r;
    int unsigned        elapsed;
    int                 pos;
    logic [DELAY_W-1:0] rel;
    r = '{status: ST_OK, expired_valid: 1'b0, expired_id: '0, last_result: 1'b1};
    elapsed = 0;
    pos = 0;
    case (c.operation)
      OP_SET: begin
        if (timer_count >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          // Pass every entry that expires no later than the new one.
          while (pos < timer_count && elapsed + timer_deltas[pos] <= c.delay_ms) begin
            elapsed += timer_deltas[pos];
            pos++;
          end
          for (int i = timer_count; i > pos; i--) begin
            timer_ids[i] = timer_ids[i - 1];
            timer_deltas[i] = timer_deltas[i - 1];
          end
          rel = DELAY_W'(c.delay_ms - elapsed);
          timer_ids[pos] = c.timer_id;
          timer_deltas[pos] = rel;
          timer_count++;
          if (pos + 1 < timer_count) begin
            timer_deltas[pos + 1] = timer_deltas[pos + 1] - rel;
          end
        end
        expected_results.push_back(r);
      end
      OP_CANCEL: begin
        if (timer_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          while (pos < timer_count && timer_ids[pos] != c.timer_id) pos++;
          if (pos >= timer_count) begin
            r.status = ST_NOT_FOUND;
          end else begin
            if (pos + 1 < timer_count) begin
              timer_deltas[pos + 1] = timer_deltas[pos + 1] + timer_deltas[pos];
            end
            timer_remove(pos);
          end
        end
        expected_results.push_back(r);
      end
      OP_TICK: begin
        // A head already at zero stays at zero and fires on this tick.
        if (timer_count > 0 && timer_deltas[0] != '0) begin
          timer_deltas[0] = timer_deltas[0] - 1'b1;
        end
        while (timer_count > 0 && timer_deltas[0] == '0) begin
          r.expired_valid = 1'b1;
          r.expired_id = timer_ids[0];
          timer_remove(0);
          r.last_result = !(timer_count > 0 && timer_deltas[0] == '0);
          expected_results.push_back(r);
        end
        if (!r.expired_valid) begin
          expected_results.push_back(r);
        end
      end
      default: begin
        expected_results.push_back(r);
      end
    endcase
  endfunction

  task automatic queue_cmd(logic [1:0] op, logic [DELAY_W-1:0] delay, logic [ID_W-1:0] id,
                           bit drain);
    queued_cmd_t q;
    q.cmd.operation = op;
    q.cmd.delay_ms = delay;
    q.cmd.timer_id = id;
    q.drain_first = drain;
    cmd_backlog.push_back(q);
    total_items++;
    if (op == OP_SET) begin
      issued_ids.push_back(id);
    end
  endtask

  task automatic check_field(string name, logic [ID_W-1:0] want, logic [ID_W-1:0] got);
    if (got !== want) begin
      error_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Driver: presents one item at a time and after each accepted item waits a random gap, or none during a calm run.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        timer_queue_predict(command);
        accepted_items++;
        if (calm_left > 0) begin
          calm_left--;
          gap_left = 0;
        end else begin
          gap_left = $urandom_range(0, 4);
          if ($urandom_range(0, 7) == 0) begin
            calm_left = $urandom_range(8, 24);
          end
        end
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (cmd_backlog.size() > 0 &&
                     !(cmd_backlog[0].drain_first && expected_results.size() > 0)) begin
          command <= cmd_backlog[0].cmd;
          start <= 1'b1;
          void'(cmd_backlog.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid === 1'b1) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %h", $time, result);
      end else begin
        want = expected_results.pop_front();
        check_field("status", want.status, result.status);
        check_field("expired_valid", want.expired_valid, result.expired_valid);
        check_field("expired_id", want.expired_id, result.expired_id);
        check_field("last_result", want.last_result, result.last_result);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int                 random_start;
    int                 phase_len;
    int                 pick;
    int                 sel;
    bit                 drain;
    bit                 first_phase;
    logic [1:0]         op;
    logic [DELAY_W-1:0] delay;
    logic [ID_W-1:0]    id;

    // Directed part: empty queue, unused code, extremes, equal expiries, cancels.
    queue_cmd(OP_TICK, '0, '0, 1'b0);
    queue_cmd(OP_CANCEL, '0, 16'hFFFF, 1'b0);
    queue_cmd(OP_UNUSED, 24'hFFFFFF, 16'hFFFF, 1'b0);
    queue_cmd(OP_SET, 24'hFFFFFF, 16'hFFFF, 1'b0);
    queue_cmd(OP_SET, 24'd0, 16'h0000, 1'b0);
    queue_cmd(OP_SET, 24'd0, 16'h1234, 1'b0);
    queue_cmd(OP_SET, 24'd2, 16'hAAAA, 1'b0);
    queue_cmd(OP_SET, 24'd2, 16'h5555, 1'b0);
    queue_cmd(OP_CANCEL, 24'hFFFFFF, 16'h7777, 1'b0);
    queue_cmd(OP_TICK, 24'hFFFFFF, 16'hFFFF, 1'b0);
    queue_cmd(OP_CANCEL, '0, 16'hAAAA, 1'b0);
    queue_cmd(OP_TICK, '0, '0, 1'b0);
    queue_cmd(OP_TICK, '0, '0, 1'b0);
    queue_cmd(OP_CANCEL, '0, 16'hFFFF, 1'b0);
    queue_cmd(OP_TICK, '0, '0, 1'b0);

    random_start = total_items;
    first_phase = 1'b1;
    while (total_items - random_start < RANDOM_ITEMS) begin
      drain = first_phase || ($urandom_range(0, 2) == 0);
      if (first_phase || $urandom_range(0, 3) == 0) begin
        // Equal expiries: fill the queue past full, then tick until they all fire.
        delay = first_phase ? 24'd1 : DELAY_W'($urandom_range(0, 3));
        for (int i = 0; i < DEPTH + 1; i++) begin
          queue_cmd(OP_SET, delay, ID_W'($urandom), drain && i == 0);
        end
        for (int i = 0; i <= delay; i++) begin
          queue_cmd(OP_TICK, DELAY_W'($urandom), ID_W'($urandom), 1'b0);
        end
      end else begin
        phase_len = $urandom_range(10, 30);
        for (int i = 0; i < phase_len; i++) begin
          pick = $urandom_range(0, 99);
          delay = DELAY_W'($urandom);
          id = $urandom_range(0, 1) ? ID_W'($urandom_range(0, 7)) : ID_W'($urandom);
          if (pick < 40) begin
            op = OP_SET;
            sel = $urandom_range(0, 19);
            if (sel < 16) begin
              delay = DELAY_W'($urandom_range(0, 6));
            end else if (sel < 19) begin
              delay = DELAY_W'($urandom_range(7, 255));
            end
            if (delay >= LONG_DELAY) begin
              long_ids.push_back(id);
            end
          end else if (pick < 80) begin
            op = OP_TICK;
          end else if (pick < 95) begin
            op = OP_CANCEL;
            if (issued_ids.size() > 0 && $urandom_range(0, 3) != 0) begin
              id = issued_ids[$urandom_range(0, issued_ids.size() - 1)];
            end
          end else begin
            op = OP_UNUSED;
          end
          queue_cmd(op, delay, id, drain && i == 0);
        end
        // Long timers would never fire within the run, so clear them out.
        while (long_ids.size() > 0) begin
          queue_cmd(OP_CANCEL, DELAY_W'($urandom), long_ids.pop_front(), 1'b0);
        end
      end
      first_phase = 1'b0;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    while (accepted_items < total_items || expected_results.size() > 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
